>>> design/lms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lms_pkg: shared types and microcode for the line staircase rasterizer
// Beat formats, result kinds, and the control store of the sequencer.
// ============================================================================
package lms_pkg;

    localparam int COORD_BITS = 10;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_SEG   = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERR   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [COORD_BITS-1:0] first_col;
        logic [COORD_BITS-1:0] first_row;
        logic [COORD_BITS-1:0] second_col;
        logic [COORD_BITS-1:0] second_row;
    } t_in_beat;

    typedef struct packed {
        t_kind                 kind;
        logic [COORD_BITS-1:0] col_from;
        logic [COORD_BITS-1:0] row_at;
        logic [COORD_BITS-1:0] col_to;
        logic                  last;
    } t_out_beat;

    // Sequencer step addresses.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_CHECK = 4'd1,
        ST_START = 4'd2,
        ST_DIV   = 4'd3,
        ST_FIX   = 4'd4,
        ST_FIRST = 4'd5,
        ST_SEG   = 4'd6,
        ST_END   = 4'd7,
        ST_ERR   = 4'd8
    } t_step;

    // Datapath operation of one control word.
    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_LOAD      = 3'd1,
        OP_DIV_START = 3'd2,
        OP_DIV_FIX   = 3'd3,
        OP_SEG_FIRST = 3'd4,
        OP_SEG_ADV   = 3'd5
    } t_op;

    // Branch condition of one control word.
    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_IN_VALID  = 3'd1,
        COND_SPAN_BIG  = 3'd2,
        COND_SPAN_ZERO = 3'd3,
        COND_DIV_DONE  = 3'd4,
        COND_SEG_LAST  = 3'd5
    } t_cond;

    typedef struct packed {
        t_op   op;
        logic  emit;
        t_kind kind;
        logic  last;
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
    } t_uword;

    // Control store. A step whose emit bit is set waits for a free output slot.
    function automatic t_uword uop_rom(input t_step step);
        t_uword w;
        begin
            unique case (step)
                ST_IDLE:  w = '{OP_LOAD, 1'b0, KIND_START, 1'b0, COND_IN_VALID,
                                ST_CHECK, ST_IDLE};
                ST_CHECK: w = '{OP_NONE, 1'b0, KIND_START, 1'b0, COND_SPAN_BIG,
                                ST_ERR, ST_START};
                ST_START: w = '{OP_DIV_START, 1'b1, KIND_START, 1'b0, COND_SPAN_ZERO,
                                ST_END, ST_DIV};
                ST_DIV:   w = '{OP_NONE, 1'b0, KIND_START, 1'b0, COND_DIV_DONE,
                                ST_FIX, ST_DIV};
                ST_FIX:   w = '{OP_DIV_FIX, 1'b0, KIND_START, 1'b0, COND_ALWAYS,
                                ST_FIRST, ST_FIRST};
                ST_FIRST: w = '{OP_SEG_FIRST, 1'b0, KIND_START, 1'b0, COND_ALWAYS,
                                ST_SEG, ST_SEG};
                ST_SEG:   w = '{OP_SEG_ADV, 1'b1, KIND_SEG, 1'b0, COND_SEG_LAST,
                                ST_END, ST_SEG};
                ST_END:   w = '{OP_NONE, 1'b1, KIND_END, 1'b1, COND_ALWAYS,
                                ST_IDLE, ST_IDLE};
                ST_ERR:   w = '{OP_NONE, 1'b1, KIND_ERR, 1'b1, COND_ALWAYS,
                                ST_IDLE, ST_IDLE};
                default:  w = '{OP_NONE, 1'b0, KIND_START, 1'b0, COND_ALWAYS,
                                ST_IDLE, ST_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/line_to_mesh_staircase_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// line_to_mesh_staircase_top: staircase rasterizer for a line on a mesh
// Orders the endpoints, then emits start point, unit segments and end point.
// ============================================================================
// Sequence: the start point is emitted after the span check; the first segment
// follows after the serial slope divide, its sign fix and the first advance,
// then one beat per cycle while the output register is not stalled.
// Throughput: one line at a time; the next input beat is taken once the end
// (or error) beat is in the output register.
// Reset: synchronous, active low; the sequencer returns to idle, output empty.
// ============================================================================
module line_to_mesh_staircase_top #(
    parameter int MAX_SPAN = 62
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire lms_pkg::t_in_beat i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output lms_pkg::t_out_beat     o_out_data
);
    import lms_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int SPAN_W = $clog2(MAX_SPAN + 1);
    localparam int DEN_W  = SPAN_W + 1;
    localparam int SW_EXT = (CB > SPAN_W) ? CB : SPAN_W;
    // The running row accumulator needs headroom past the coordinate range,
    // because the final advance after the last segment may overshoot.
    localparam int QW     = CB + 3;

    // Sequencer state.
    t_step r_pc, n_pc;
    t_uword uw;
    logic cond_true;
    logic fire;
    logic out_free;

    // Line registers, loaded when the input beat is taken.
    logic [CB-1:0]        r_jl, r_kl, r_jh, r_kh;
    logic [CB-1:0]        n_jl, n_kl, n_jh, n_kh;
    logic signed [CB:0]   r_d, n_d;
    logic [SPAN_W-1:0]    r_span, n_span;
    logic                 r_big, n_big;

    // Slope terms: one row step is a quotient plus a remainder over 2*span.
    logic signed [QW-1:0] r_qd, n_qd;
    logic [DEN_W-1:0]     r_rd, n_rd;
    logic signed [QW-1:0] r_q2, n_q2;
    logic [DEN_W-1:0]     r_r2, n_r2;

    // Running row (quotient part and fractional remainder) and segment index.
    logic signed [QW-1:0] r_q, n_q;
    logic [DEN_W-1:0]     r_r, n_r;
    logic [SPAN_W-1:0]    r_seg, n_seg;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out, n_out;

    // Divider interface.
    logic                 div_start;
    logic                 div_done;
    logic [CB-1:0]        div_quot;
    logic [DEN_W-1:0]     div_rem;
    logic [CB-1:0]        d_abs;

    logic [DEN_W-1:0]     den;
    logic                 span_zero;
    logic                 seg_last;

    // Ordering of a fresh input beat.
    logic                 left_first;
    logic [CB-1:0]        ld_jl, ld_kl, ld_jh, ld_kh;
    logic [SW_EXT-1:0]    ld_span;

    // Shared row advance: adds a quotient and remainder step to a base.
    logic signed [QW-1:0] adv_q_base, adv_qd, adv_q;
    logic [DEN_W-1:0]     adv_r_base, adv_rd, adv_r;
    logic [DEN_W:0]       adv_sum;
    logic                 adv_wrap;

    // Sign fix of the divider result into a floor quotient and remainder.
    logic signed [QW-1:0] fix_qm, fix_qd, fix_q2;
    logic [DEN_W-1:0]     fix_rd, fix_r2;
    logic [DEN_W:0]       fix_r2raw;
    logic                 fix_wrap;

    assign uw        = uop_rom(r_pc);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign fire      = !uw.emit || out_free;
    assign den       = {r_span, 1'b0};
    assign span_zero = (r_span == '0);
    assign seg_last  = (SPAN_W'(r_seg + SPAN_W'(1)) == r_span);
    assign d_abs     = r_d[CB] ? CB'(-r_d) : r_d[CB-1:0];
    assign div_start = fire && (uw.op == OP_DIV_START);

    assign o_in_stall  = (r_pc != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    lms_div #(
        .DVD_W (CB),
        .DVS_W (DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (d_abs),
        .i_divisor  (den),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Branch condition of the current control word.
    always_comb begin
        unique case (uw.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_IN_VALID:  cond_true = i_in_valid;
            COND_SPAN_BIG:  cond_true = r_big;
            COND_SPAN_ZERO: cond_true = span_zero;
            COND_DIV_DONE:  cond_true = div_done;
            COND_SEG_LAST:  cond_true = seg_last;
            default:        cond_true = 1'b0;
        endcase
    end

    // Next step. A step that emits holds until the output register frees up.
    always_comb begin
        n_pc = r_pc;
        if (fire) begin
            n_pc = cond_true ? uw.tgt_t : uw.tgt_f;
        end
    end

    // Endpoint ordering: the first pair is left only if its column is
    // strictly smaller, so equal columns take the second pair as the start.
    always_comb begin
        left_first = i_in_data.first_col < i_in_data.second_col;
        ld_jl      = left_first ? i_in_data.first_col  : i_in_data.second_col;
        ld_kl      = left_first ? i_in_data.first_row  : i_in_data.second_row;
        ld_jh      = left_first ? i_in_data.second_col : i_in_data.first_col;
        ld_kh      = left_first ? i_in_data.second_row : i_in_data.first_row;
        ld_span    = SW_EXT'(ld_jh) - SW_EXT'(ld_jl);
    end

    // The first segment starts from row kl with remainder span (the +1/2
    // term) and advances by d / 2span; later segments advance by 2d / 2span.
    always_comb begin
        if (uw.op == OP_SEG_FIRST) begin
            adv_q_base = $signed({{(QW-CB){1'b0}}, r_kl});
            adv_r_base = DEN_W'(r_span);
            adv_qd     = r_qd;
            adv_rd     = r_rd;
        end else begin
            adv_q_base = r_q;
            adv_r_base = r_r;
            adv_qd     = r_q2;
            adv_rd     = r_r2;
        end
        adv_sum  = {1'b0, adv_r_base} + {1'b0, adv_rd};
        adv_wrap = adv_sum >= {1'b0, den};
        adv_r    = adv_wrap ? DEN_W'(adv_sum - {1'b0, den}) : adv_sum[DEN_W-1:0];
        adv_q    = adv_q_base + adv_qd + $signed({{(QW-1){1'b0}}, adv_wrap});
    end

    // The divider works on |d|; a negative d with a nonzero remainder
    // rounds the quotient down by one and flips the remainder.
    always_comb begin
        fix_qm    = $signed({{(QW-CB){1'b0}}, div_quot});
        if (!r_d[CB]) begin
            fix_qd = fix_qm;
            fix_rd = div_rem;
        end else if (div_rem == '0) begin
            fix_qd = -fix_qm;
            fix_rd = '0;
        end else begin
            fix_qd = -fix_qm - QW'(1);
            fix_rd = den - div_rem;
        end
        fix_r2raw = {fix_rd, 1'b0};
        fix_wrap  = fix_r2raw >= {1'b0, den};
        fix_r2    = fix_wrap ? DEN_W'(fix_r2raw - {1'b0, den}) : fix_r2raw[DEN_W-1:0];
        fix_q2    = (fix_qd <<< 1) + $signed({{(QW-1){1'b0}}, fix_wrap});
    end

    // Datapath updates under the current operation.
    always_comb begin
        n_jl   = r_jl;
        n_kl   = r_kl;
        n_jh   = r_jh;
        n_kh   = r_kh;
        n_d    = r_d;
        n_span = r_span;
        n_big  = r_big;
        n_qd   = r_qd;
        n_rd   = r_rd;
        n_q2   = r_q2;
        n_r2   = r_r2;
        n_q    = r_q;
        n_r    = r_r;
        n_seg  = r_seg;
        if (fire) begin
            unique case (uw.op)
                OP_LOAD: begin
                    if (i_in_valid) begin
                        n_jl   = ld_jl;
                        n_kl   = ld_kl;
                        n_jh   = ld_jh;
                        n_kh   = ld_kh;
                        n_d    = $signed({1'b0, ld_kh}) - $signed({1'b0, ld_kl});
                        n_span = ld_span[SPAN_W-1:0];
                        n_big  = ld_span > SW_EXT'(MAX_SPAN);
                    end
                end
                OP_DIV_FIX: begin
                    n_qd = fix_qd;
                    n_rd = fix_rd;
                    n_q2 = fix_q2;
                    n_r2 = fix_r2;
                end
                OP_SEG_FIRST: begin
                    n_q   = adv_q;
                    n_r   = adv_r;
                    n_seg = '0;
                end
                OP_SEG_ADV: begin
                    n_q   = adv_q;
                    n_r   = adv_r;
                    n_seg = SPAN_W'(r_seg + SPAN_W'(1));
                end
                OP_NONE, OP_DIV_START: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Output beat assembly. The register keeps its beat while stalled.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (fire && uw.emit) begin
            n_out_valid   = 1'b1;
            n_out.kind    = uw.kind;
            n_out.last    = uw.last;
            unique case (uw.kind)
                KIND_START: begin
                    n_out.col_from = r_jl;
                    n_out.row_at   = r_kl;
                    n_out.col_to   = r_jl;
                end
                KIND_SEG: begin
                    n_out.col_from = r_jl + CB'(r_seg);
                    n_out.row_at   = r_q[CB-1:0];
                    n_out.col_to   = r_jl + CB'(r_seg) + CB'(1);
                end
                KIND_END: begin
                    n_out.col_from = r_jh;
                    n_out.row_at   = r_kh;
                    n_out.col_to   = r_jh;
                end
                KIND_ERR: begin
                    n_out.col_from = '0;
                    n_out.row_at   = '0;
                    n_out.col_to   = '0;
                end
            endcase
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_jl   <= n_jl;
        r_kl   <= n_kl;
        r_jh   <= n_jh;
        r_kh   <= n_kh;
        r_d    <= n_d;
        r_span <= n_span;
        r_big  <= n_big;
        r_qd   <= n_qd;
        r_rd   <= n_rd;
        r_q2   <= n_q2;
        r_r2   <= n_r2;
        r_q    <= n_q;
        r_r    <= n_r;
        r_seg  <= n_seg;
        r_out  <= n_out;
    end

    // A taken input beat always moves the sequencer to the span check.
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_pc == ST_CHECK))
        else $error("input beat taken but sequencer did not start the line");

    // While segments are emitted the running row stays on the mesh.
    a_seg_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ST_SEG) |-> (r_q[QW-1:CB] == '0))
        else $error("segment row left the coordinate range");

    // The slope fix-up only runs on a finished quotient.
    a_fix_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ST_FIX) |-> div_done)
        else $error("slope fix-up reached while divider busy");

    // An error beat is the sole beat of its line and carries zero fields.
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_ERR) |->
            (r_out.last && r_out.col_from == '0 && r_out.row_at == '0))
        else $error("error beat malformed");

endmodule
`default_nettype wire

>>> design/lms_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lms_div: serial restoring divider
// Produces one quotient bit per cycle; done is high whenever it is not busy.
// ============================================================================
module lms_div #(
    parameter int DVD_W = 10,
    parameter int DVS_W = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quot,
    output logic      [DVS_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic             ge;
    logic [DVS_W:0]   rem_diff;

    always_comb begin
        rem_sh   = {r_rem, r_quot[DVD_W-1]};
        ge       = rem_sh >= {1'b0, r_dvs};
        rem_diff = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DVD_W-2:0], ge};
            r_rem  <= rem_diff[DVS_W-1:0];
        end
    end

    assign o_done = !r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the line staircase rasterizer
// Sends endpoint pairs and predicts the start point, unit segments and end
// point of each line (or the error beat for a long span) in exact integer
// math. Every output beat is checked in order against that prediction.
// ============================================================================
module tb;
    import lms_pkg::*;

    localparam int MAX_SPAN     = 62;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int SETTLE_CYCLES = 100;
    // The slowest legal run is about 160 lines of 64 beats, each beat often
    // stalled by the receiver, and the limit leaves a wide margin for it.
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_data = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_data;

    // Beats predicted for accepted lines, oldest first.
    t_out_beat pending_beats[$];

    int fail_count = 0;
    int cycle_count = 0;
    // Chance, in percent, that the sender leaves a cycle empty before a beat
    // and that the receiver stalls in a given cycle.
    int send_gap_pct = 0;
    int out_stall_pct = 0;

    line_to_mesh_staircase_top #(
        .MAX_SPAN(MAX_SPAN)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------------
    function automatic t_out_beat make_beat(input t_kind k, input int cf, input int row,
                                            input int ct, input logic is_last);
        t_out_beat b;
        b.kind     = k;
        b.col_from = cf[COORD_BITS-1:0];
        b.row_at   = row[COORD_BITS-1:0];
        b.col_to   = ct[COORD_BITS-1:0];
        b.last     = is_last;
        return b;
    endfunction

    // Orders the endpoints and queues the beats the line should produce. The
    // first pair is the left end only when its column is strictly smaller, so
    // equal columns put the second pair first.
    function automatic void rasterize_line(input t_in_beat line);
        int      left_col;
        int      left_row;
        int      right_col;
        int      right_row;
        int      span;
        longint  rise;
        longint  num;
        longint  den;
        longint  row;
        if (line.first_col < line.second_col) begin
            left_col  = line.first_col;
            left_row  = line.first_row;
            right_col = line.second_col;
            right_row = line.second_row;
        end else begin
            left_col  = line.second_col;
            left_row  = line.second_row;
            right_col = line.first_col;
            right_row = line.first_row;
        end
        span = right_col - left_col;
        if (span > MAX_SPAN) begin
            pending_beats.push_back(make_beat(KIND_ERR, 0, 0, 0, 1'b1));
            return;
        end
        pending_beats.push_back(make_beat(KIND_START, left_col, left_row, left_col, 1'b0));
        rise = longint'(right_row) - longint'(left_row);
        den  = 2 * span;
        // Row of segment i is the line height at its midpoint, rounded half up:
        // floor((2*span*left_row + rise*(2i+1) + span) / (2*span)).
        for (int i = 0; i < span; i++) begin
            num = den * left_row + rise * (2 * i + 1) + span;
            row = (num > 0) ? num / den : 0;
            pending_beats.push_back(make_beat(KIND_SEG, left_col + i, int'(row),
                                              left_col + i + 1, 1'b0));
        end
        pending_beats.push_back(make_beat(KIND_END, right_col, right_row, right_col, 1'b1));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Offers one line at the falling edge, after any random idle cycles, and
    // holds it until a rising edge sees it taken. The prediction is queued at
    // that edge; no result of this line can appear at the same edge.
    task automatic send_line(input t_in_beat line);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= line;
        do @(posedge i_clk); while (in_stall);
        rasterize_line(line);
    endtask

    task automatic send_pair(input int c1, input int r1, input int c2, input int r2);
        t_in_beat line;
        line.first_col  = c1[COORD_BITS-1:0];
        line.first_row  = r1[COORD_BITS-1:0];
        line.second_col = c2[COORD_BITS-1:0];
        line.second_row = r2[COORD_BITS-1:0];
        send_line(line);
    endtask

    // Drops valid and holds off until every predicted beat has been seen.
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
    endtask

    // Rows lean toward the mesh edges now and then.
    function automatic int pick_row();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) return 0;
        if (sel < 16) return COORD_MAX;
        return $urandom_range(0, COORD_MAX);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Points, vertical lines, the widest legal span, unit spans, flat and
    // steep lines in both directions, and alternating bit patterns.
    task automatic test_directed_lines();
        send_pair(0, 0, 0, 0);
        send_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        // Equal columns: the second pair is taken as the left end.
        send_pair(5, 0, 5, COORD_MAX);
        send_pair(5, COORD_MAX, 5, 0);
        send_pair(0, 0, MAX_SPAN, COORD_MAX);
        send_pair(MAX_SPAN, COORD_MAX, 0, 0);
        send_pair(COORD_MAX - MAX_SPAN, COORD_MAX, COORD_MAX, 0);
        send_pair(0, 0, 1, COORD_MAX);
        send_pair(COORD_MAX, 0, COORD_MAX - 1, COORD_MAX);
        send_pair(10, 500, 20, 500);
        // Rise of half the span lands segment midpoints on quarter rows.
        send_pair(100, 7, 104, 9);
        send_pair(0, COORD_MAX, 3, 0);
        send_pair(341, 682, 403, 341);
    endtask

    // Spans just inside and just past the limit, and the widest possible.
    task automatic test_span_limit();
        send_pair(0, 0, MAX_SPAN + 1, 5);
        send_pair(MAX_SPAN + 1, 5, 0, 0);
        send_pair(0, 0, COORD_MAX, COORD_MAX);
        send_pair(COORD_MAX, 0, 0, COORD_MAX);
        send_pair(960, 3, 960 + MAX_SPAN, 4);
        send_pair(682, 341, 682 + MAX_SPAN + 1, 682);
        send_pair(100, 100, 100 + MAX_SPAN - 1, 100);
        wait_drained();
    endtask

    // Mostly legal lines with random position, span, slope and direction; a
    // tenth sit at the span limit and a tenth are fully random endpoints,
    // which are almost always too long. Now and then the sender drains.
    task automatic test_random_lines(input int count);
        int sel;
        int span;
        int left_col;
        int row_a;
        int row_b;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 90) begin
                if (sel < 40) span = $urandom_range(0, 8);
                else if (sel < 80) span = $urandom_range(0, MAX_SPAN);
                else span = $urandom_range(MAX_SPAN, MAX_SPAN + 1);
                left_col = $urandom_range(0, COORD_MAX - span);
                row_a = pick_row();
                row_b = pick_row();
                if ($urandom_range(0, 1) != 0)
                    send_pair(left_col, row_a, left_col + span, row_b);
                else
                    send_pair(left_col + span, row_b, left_col, row_a);
            end else begin
                send_pair($urandom_range(0, COORD_MAX), pick_row(),
                          $urandom_range(0, COORD_MAX), pick_row());
            end
            if ($urandom_range(0, 99) < 3) wait_drained();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall, then in-order checking of every taken beat.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge i_clk) begin : beat_check
        t_out_beat want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_beats.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display({"%0t: beat with nothing expected: ",
                              "kind=%0d from=%0d row=%0d to=%0d last=%0b"},
                             $realtime, out_data.kind, out_data.col_from, out_data.row_at,
                             out_data.col_to, out_data.last);
            end else begin
                want = pending_beats.pop_front();
                if (out_data.kind !== want.kind || out_data.col_from !== want.col_from ||
                    out_data.row_at !== want.row_at || out_data.col_to !== want.col_to ||
                    out_data.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: beat mismatch", $realtime);
                        $display("  expected kind=%0d from=%0d row=%0d to=%0d last=%0b",
                                 want.kind, want.col_from, want.row_at, want.col_to, want.last);
                        $display("  actual   kind=%0d from=%0d row=%0d to=%0d last=%0b",
                                 out_data.kind, out_data.col_from, out_data.row_at,
                                 out_data.col_to, out_data.last);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        // Reset is held low from the start and released at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: a dense sender against a receiver that stalls heavily,
        // so lines queue up behind the output register.
        send_gap_pct  = 7;
        out_stall_pct = 79;
        test_directed_lines();
        test_span_limit();
        test_random_lines(50);

        // Phase two: a sparse sender and a receiver that rarely stalls, so
        // the block is often idle between lines.
        send_gap_pct  = 79;
        out_stall_pct = 7;
        test_random_lines(45);

        // Phase three: back to back with no idle cycles on either side.
        send_gap_pct  = 0;
        out_stall_pct = 0;
        test_random_lines(45);

        // Everything predicted has been seen; leave room for any stray beat.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
design/lms_pkg.sv
design/lms_div.sv
design/line_to_mesh_staircase_top.sv
dv/tb.sv
